[design/mm64_pkg.sv]
// Package for the 64-bit Montgomery multiplier: payload structs, codes and
// the command and status structs between controller and datapath.
// No dependencies.
package mm64_pkg;

    localparam logic [1:0]  FUNC_PREPARE = 2'd0;
    localparam logic [1:0]  FUNC_PRODUCT = 2'd1;
    localparam logic [1:0]  FUNC_CONVERT = 2'd2;

    localparam logic [63:0] MOD_RESET    = 64'd4294967297;
    localparam logic [31:0] TOP_BIT32    = 32'h8000_0000;
    localparam logic [31:0] NEWTON_TWO   = 32'd2;
    localparam int          RSQ_EXPONENT = 72;
    localparam int          DBL_EXTRA    = RSQ_EXPONENT - 64;
    localparam int          NWT_STEPS    = 4;
    localparam int          SQUARINGS    = 3;
    localparam int          MONT_STEPS   = 12;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_MOD  = 2'd1,
        STATUS_NOT_PREP = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result;
        status_t     status;
    } out_item_t;

    typedef enum logic [3:0] {
        MS_HOLD,
        MS_ALO_BLO,
        MS_AHI_BLO,
        MS_ALO_BHI,
        MS_AHI_BHI,
        MS_T0_W,
        MS_P_NLO,
        MS_M_NHI,
        MS_N0_W,
        MS_W_FIX
    } mul_sel_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_LOAD,
        DP_CLEAR,
        DP_ACC_A,
        DP_ACC_B,
        DP_ACC_C,
        DP_ACC_D,
        DP_ACC_E,
        DP_ACC_F,
        DP_FINAL,
        DP_PREP_INIT,
        DP_W_UPD,
        DP_NORM_SHIFT,
        DP_DBL_INIT,
        DP_DBL_A,
        DP_DBL_B,
        DP_SHIFT,
        DP_RSQ
    } dp_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        dp_op_t   op;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_bad;
        logic norm_top;
        logic dbl_last;
    } dp_status_t;

endpackage

[design/montgomery_mul_64bit.sv]
// Top level of the 64-bit Montgomery multiplier with R = 2^64.
// Depends on mm64_pkg, mm64_ctrl and mm64_dp.
//
// Usage: write the odd modulus (high word nonzero) on the cfg channel while
// the block is idle, then send a prepare item (func 0). Its result is
// R^2 mod n, or status 1 with a zero result if the modulus is unusable.
// Product items (func 1) return a*b/R mod n and convert items (func 2)
// return a*R mod n; before a successful prepare they give status 2.
// Any modulus write cancels the prepare. Function code three returns zero.
// The block works on one item at a time. A product or a convert runs through
// the twelve steps of the shared 32x32 multiplier and limb adders. An item
// that only returns a status is valid in the cycle after acceptance. A
// prepare runs through the Newton steps, the one-bit normalising shifts, the
// modular doublings and three squarings.
// The result is held on m_data while m_ready is low, and no new item is
// taken until it has been delivered. Reset loads the modulus 2^32 + 1 and
// clears the prepared state.
module montgomery_mul_64bit
    import mm64_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    dp_cmd_t     cmd;
    dp_status_t  dp_status;
    status_t     out_status;
    logic [63:0] dp_result;
    logic        cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    mm64_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .func       (s_data.func),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cfg_we     (cfg_we),
        .dp_status  (dp_status),
        .cmd        (cmd),
        .out_status (out_status)
    );

    mm64_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_item  (s_data),
        .cmd      (cmd),
        .status   (dp_status),
        .result   (dp_result)
    );

    assign m_data.result = dp_result;
    assign m_data.status = out_status;

    a_busy_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input ready while a result is pending.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Input still ready after an item was accepted.");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_OK) |-> (m_data.result == '0))
        else $error("Nonzero result delivered with an error status.");

endmodule

[design/mm64_dp.sv]
// Datapath of the Montgomery multiplier: one shared 32x32 multiplier, the
// limb accumulators, the prepare arithmetic and the modulus register.
// Depends on mm64_pkg.
module mm64_dp
    import mm64_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [63:0] cfg_data,
    input  in_item_t    in_item,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [63:0] result
);

    logic [63:0] mod_reg,  mod_next;
    logic [31:0] w_reg,    w_next;
    logic [63:0] rsq_reg,  rsq_next;
    logic [63:0] a_reg,    a_next;
    logic [63:0] b_reg,    b_next;
    logic [63:0] acc_reg,  acc_next;
    logic [63:0] p_reg,    p_next;
    logic [31:0] m_reg,    m_next;
    logic [31:0] t0_reg,   t0_next;
    logic [31:0] t1_reg,   t1_next;
    logic [31:0] t2_reg,   t2_next;
    logic [31:0] c_reg,    c_next;
    logic [63:0] norm_reg, norm_next;
    logic [4:0]  lz_reg,   lz_next;
    logic [5:0]  iter_reg, iter_next;

    logic [31:0] mul_x, mul_y;
    logic [31:0] add_x, add_y;
    logic [63:0] limb_sum;
    logic [32:0] hi_sum;
    logic [63:0] full, full_diff, fin_res, dbl_shift;

    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (cmd.mul_sel)
            MS_ALO_BLO: begin mul_x = a_reg[31:0];   mul_y = b_reg[31:0];   end
            MS_AHI_BLO: begin mul_x = a_reg[63:32];  mul_y = b_reg[31:0];   end
            MS_ALO_BHI: begin mul_x = a_reg[31:0];   mul_y = b_reg[63:32];  end
            MS_AHI_BHI: begin mul_x = a_reg[63:32];  mul_y = b_reg[63:32];  end
            MS_T0_W:    begin mul_x = t0_reg;        mul_y = w_reg;         end
            MS_P_NLO:   begin mul_x = p_reg[31:0];   mul_y = mod_reg[31:0]; end
            MS_M_NHI:   begin mul_x = m_reg;         mul_y = mod_reg[63:32]; end
            MS_N0_W:    begin mul_x = mod_reg[31:0]; mul_y = w_reg;         end
            MS_W_FIX:   begin mul_x = w_reg;         mul_y = NEWTON_TWO + p_reg[31:0]; end
            default:    begin mul_x = '0;            mul_y = '0;            end
        endcase
    end

    always_comb begin
        add_x = '0;
        add_y = '0;
        case (cmd.op)
            DP_ACC_B:           add_x = c_reg;
            DP_ACC_C, DP_ACC_E: add_x = t0_reg;
            DP_ACC_D, DP_ACC_F: begin add_x = c_reg; add_y = t1_reg; end
            default:            add_x = '0;
        endcase
    end

    assign limb_sum  = p_reg + {32'b0, add_x} + {32'b0, add_y};
    assign hi_sum    = {1'b0, limb_sum[63:32]} + {1'b0, t2_reg};
    assign full      = {t1_reg, t0_reg};
    assign full_diff = full - mod_reg;
    assign fin_res   = (t2_reg != '0 || full >= mod_reg) ? full_diff : full;
    assign dbl_shift = {acc_reg[62:0], 1'b0};

    always_comb begin
        mod_next  = cfg_we ? cfg_data : mod_reg;
        w_next    = w_reg;
        rsq_next  = rsq_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        p_next    = (cmd.mul_sel != MS_HOLD) ? 64'(mul_x) * 64'(mul_y) : p_reg;
        m_next    = (cmd.mul_sel == MS_P_NLO) ? p_reg[31:0] : m_reg;
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        t2_next   = t2_reg;
        c_next    = c_reg;
        norm_next = norm_reg;
        lz_next   = lz_reg;
        iter_next = iter_reg;
        case (cmd.op)
            DP_LOAD: begin
                a_next = in_item.operand_a;
                b_next = (in_item.func == FUNC_CONVERT) ? rsq_reg : in_item.operand_b;
            end
            DP_CLEAR: acc_next = '0;
            DP_ACC_A: begin
                t0_next = p_reg[31:0];
                c_next  = p_reg[63:32];
            end
            DP_ACC_B: begin
                t1_next = limb_sum[31:0];
                t2_next = limb_sum[63:32];
            end
            DP_ACC_C: c_next = limb_sum[63:32];
            DP_ACC_D: begin
                t0_next = limb_sum[31:0];
                t1_next = hi_sum[31:0];
                t2_next = {31'b0, hi_sum[32]};
            end
            DP_ACC_E: begin
                t0_next = limb_sum[31:0];
                c_next  = limb_sum[63:32];
            end
            DP_ACC_F: begin
                t1_next = limb_sum[31:0];
                t2_next = hi_sum[31:0];
            end
            DP_FINAL: begin
                acc_next = fin_res;
                a_next   = fin_res;
                b_next   = fin_res;
            end
            DP_PREP_INIT: begin
                w_next    = NEWTON_TWO + mod_reg[31:0];
                norm_next = mod_reg;
                lz_next   = '0;
            end
            DP_W_UPD: w_next = p_reg[31:0];
            DP_NORM_SHIFT: begin
                norm_next = {norm_reg[62:0], 1'b0};
                lz_next   = lz_reg + 5'd1;
            end
            DP_DBL_INIT: begin
                acc_next  = '0 - norm_reg;
                iter_next = {1'b0, lz_reg} + 6'(DBL_EXTRA);
            end
            DP_DBL_A: acc_next = acc_reg[63] ? dbl_shift - norm_reg : dbl_shift;
            DP_DBL_B: begin
                if (acc_reg >= norm_reg) begin
                    acc_next = acc_reg - norm_reg;
                end
                iter_next = iter_reg - 6'd1;
            end
            DP_SHIFT: begin
                acc_next = acc_reg >> lz_reg;
                a_next   = acc_reg >> lz_reg;
                b_next   = acc_reg >> lz_reg;
            end
            DP_RSQ: rsq_next = acc_reg;
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= MOD_RESET;
            w_reg   <= '0;
            rsq_reg <= '0;
        end else begin
            mod_reg <= mod_next;
            w_reg   <= w_next;
            rsq_reg <= rsq_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        p_reg    <= p_next;
        m_reg    <= m_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        c_reg    <= c_next;
        norm_reg <= norm_next;
        lz_reg   <= lz_next;
        iter_reg <= iter_next;
    end

    assign status.mod_bad  = !mod_reg[0] || (mod_reg[63:32] == '0);
    assign status.norm_top = (norm_reg[63:32] & TOP_BIT32) != '0;
    assign status.dbl_last = (iter_reg == 6'd1);
    assign result          = acc_reg;

endmodule

[design/mm64_ctrl.sv]
// Controller of the Montgomery multiplier: the state machine that steps the
// datapath through prepare, product and convert, and holds the status.
// Depends on mm64_pkg.
module mm64_ctrl
    import mm64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] func,
    output logic       m_valid,
    input  logic       m_ready,
    input  logic       cfg_we,
    input  dp_status_t dp_status,
    output dp_cmd_t    cmd,
    output status_t    out_status
);

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_NWT_INIT = 13'b0000000000010,
        ST_NWT_MUL1 = 13'b0000000000100,
        ST_NWT_MUL2 = 13'b0000000001000,
        ST_NWT_UPD  = 13'b0000000010000,
        ST_NORM     = 13'b0000000100000,
        ST_DBL_INIT = 13'b0000001000000,
        ST_DBL_A    = 13'b0000010000000,
        ST_DBL_B    = 13'b0000100000000,
        ST_SHIFT    = 13'b0001000000000,
        ST_MONT     = 13'b0010000000000,
        ST_RSQ      = 13'b0100000000000,
        ST_OUT      = 13'b1000000000000
    } state_t;

    localparam logic [3:0] MONT_LAST = 4'(MONT_STEPS - 1);
    localparam logic [3:0] NWT_LAST  = 4'(NWT_STEPS - 1);
    localparam logic [1:0] SQ_LAST   = 2'(SQUARINGS - 1);

    state_t      state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  sq_reg, sq_next;
    logic        prep_job_reg, prep_job_next;
    logic        prepared_reg, prepared_next;
    status_t     status_reg, status_next;

    function automatic dp_cmd_t mont_step(input logic [3:0] k);
        dp_cmd_t c;
        case (k)
            4'd0:    begin c.mul_sel = MS_ALO_BLO; c.op = DP_NONE;  end
            4'd1:    begin c.mul_sel = MS_AHI_BLO; c.op = DP_ACC_A; end
            4'd2:    begin c.mul_sel = MS_T0_W;    c.op = DP_ACC_B; end
            4'd3:    begin c.mul_sel = MS_P_NLO;   c.op = DP_NONE;  end
            4'd4:    begin c.mul_sel = MS_M_NHI;   c.op = DP_ACC_C; end
            4'd5:    begin c.mul_sel = MS_ALO_BHI; c.op = DP_ACC_D; end
            4'd6:    begin c.mul_sel = MS_AHI_BHI; c.op = DP_ACC_E; end
            4'd7:    begin c.mul_sel = MS_T0_W;    c.op = DP_ACC_F; end
            4'd8:    begin c.mul_sel = MS_P_NLO;   c.op = DP_NONE;  end
            4'd9:    begin c.mul_sel = MS_M_NHI;   c.op = DP_ACC_C; end
            4'd10:   begin c.mul_sel = MS_HOLD;    c.op = DP_ACC_D; end
            4'd11:   begin c.mul_sel = MS_HOLD;    c.op = DP_FINAL; end
            default: begin c.mul_sel = MS_HOLD;    c.op = DP_NONE;  end
        endcase
        return c;
    endfunction

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_OUT);
    assign out_status = status_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        sq_next       = sq_reg;
        prep_job_next = prep_job_reg;
        prepared_next = prepared_reg;
        status_next   = status_reg;
        cmd.mul_sel   = MS_HOLD;
        cmd.op        = DP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cnt_next    = '0;
                    sq_next     = '0;
                    status_next = STATUS_OK;
                    case (func)
                        FUNC_PREPARE: begin
                            if (dp_status.mod_bad) begin
                                prepared_next = 1'b0;
                                status_next   = STATUS_BAD_MOD;
                                cmd.op        = DP_CLEAR;
                                state_next    = ST_OUT;
                            end else begin
                                prep_job_next = 1'b1;
                                state_next    = ST_NWT_INIT;
                            end
                        end
                        FUNC_PRODUCT, FUNC_CONVERT: begin
                            if (prepared_reg) begin
                                prep_job_next = 1'b0;
                                cmd.op        = DP_LOAD;
                                state_next    = ST_MONT;
                            end else begin
                                status_next = STATUS_NOT_PREP;
                                cmd.op      = DP_CLEAR;
                                state_next  = ST_OUT;
                            end
                        end
                        default: begin
                            cmd.op     = DP_CLEAR;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_NWT_INIT: begin
                cmd.op     = DP_PREP_INIT;
                state_next = ST_NWT_MUL1;
            end
            ST_NWT_MUL1: begin
                cmd.mul_sel = MS_N0_W;
                state_next  = ST_NWT_MUL2;
            end
            ST_NWT_MUL2: begin
                cmd.mul_sel = MS_W_FIX;
                state_next  = ST_NWT_UPD;
            end
            ST_NWT_UPD: begin
                cmd.op = DP_W_UPD;
                if (cnt_reg == NWT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_NORM;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = ST_NWT_MUL1;
                end
            end
            ST_NORM: begin
                if (dp_status.norm_top) begin
                    state_next = ST_DBL_INIT;
                end else begin
                    cmd.op = DP_NORM_SHIFT;
                end
            end
            ST_DBL_INIT: begin
                cmd.op     = DP_DBL_INIT;
                state_next = ST_DBL_A;
            end
            ST_DBL_A: begin
                cmd.op     = DP_DBL_A;
                state_next = ST_DBL_B;
            end
            ST_DBL_B: begin
                cmd.op     = DP_DBL_B;
                state_next = dp_status.dbl_last ? ST_SHIFT : ST_DBL_A;
            end
            ST_SHIFT: begin
                cmd.op     = DP_SHIFT;
                state_next = ST_MONT;
            end
            ST_MONT: begin
                cmd = mont_step(cnt_reg);
                if (cnt_reg == MONT_LAST) begin
                    cnt_next = '0;
                    if (!prep_job_reg) begin
                        state_next = ST_OUT;
                    end else if (sq_reg == SQ_LAST) begin
                        state_next = ST_RSQ;
                    end else begin
                        sq_next = sq_reg + 2'd1;
                    end
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_RSQ: begin
                cmd.op        = DP_RSQ;
                prepared_next = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we) begin
            prepared_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            sq_reg       <= '0;
            prep_job_reg <= 1'b0;
            prepared_reg <= 1'b0;
            status_reg   <= STATUS_OK;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            sq_reg       <= sq_next;
            prep_job_reg <= prep_job_next;
            prepared_reg <= prepared_next;
            status_reg   <= status_next;
        end
    end

endmodule

[tb/mm64_checker.sv]
// Checker for the 64-bit Montgomery multiplier: watches the configuration, input
// and result channels, predicts each result and compares it field by field.
// Depends on mm64_pkg.
module mm64_checker
    import mm64_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    output int          n_pending,
    output int          n_errors,
    output int          n_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] modulus_q;
    logic [31:0] neg_inv_q;
    logic [63:0] r_sq_q;
    logic        prepared_q;
    out_item_t   due_results[$];
    int          errors;
    int          compared;

    initial begin
        errors     = 0;
        compared   = 0;
    end

    function automatic logic [63:0] mont_mul(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] n, input logic [31:0] w);
        logic [31:0] al, ah, bl, bh, nl, nh, t0, t1, t2, m;
        logic [63:0] s, full;
        al = a[31:0];
        ah = a[63:32];
        bl = b[31:0];
        bh = b[63:32];
        nl = n[31:0];
        nh = n[63:32];
        s  = 64'(al) * 64'(bl);
        t0 = s[31:0];
        s  = (s >> 32) + 64'(ah) * 64'(bl);
        t1 = s[31:0];
        t2 = s[63:32];
        m  = t0 * w;
        s  = 64'(t0) + 64'(m) * 64'(nl);
        s  = (s >> 32) + 64'(t1) + 64'(m) * 64'(nh);
        t0 = s[31:0];
        s  = (s >> 32) + 64'(t2);
        t1 = s[31:0];
        t2 = s[63:32];
        s  = 64'(t0) + 64'(al) * 64'(bh);
        t0 = s[31:0];
        s  = (s >> 32) + 64'(t1) + 64'(ah) * 64'(bh);
        t1 = s[31:0];
        t2 = s[63:32] + t2;
        m  = t0 * w;
        s  = 64'(t0) + 64'(m) * 64'(nl);
        s  = (s >> 32) + 64'(t1) + 64'(m) * 64'(nh);
        t0 = s[31:0];
        s  = (s >> 32) + 64'(t2);
        t1 = s[31:0];
        t2 = s[63:32];
        full = {t1, t0};
        if (t2 != 32'd0 || full >= n) begin
            return full - n;
        end
        return full;
    endfunction

    function automatic logic [31:0] newton_neg_inv(input logic [31:0] n0);
        logic [31:0] x;
        x = NEWTON_TWO + n0;
        repeat (NWT_STEPS) x = x * (NEWTON_TWO + n0 * x);
        return x;
    endfunction

    function automatic logic [63:0] r_squared_mod(input logic [63:0] n, input logic [31:0] w);
        logic [31:0] probe;
        logic [63:0] norm, acc;
        int          lz;
        lz    = 0;
        probe = TOP_BIT32;
        while (probe != 32'd0 && (n[63:32] & probe) == 32'd0) begin
            lz++;
            probe = probe >> 1;
        end
        norm = n << lz;
        acc  = 64'd0 - norm;
        for (int i = 64 - lz; i < RSQ_EXPONENT; i++) begin
            if (acc[63]) begin
                acc = acc + acc - norm;
            end else begin
                acc = acc + acc;
            end
            if (acc >= norm) begin
                acc = acc - norm;
            end
        end
        acc = acc >> lz;
        repeat (SQUARINGS) acc = mont_mul(acc, acc, n, w);
        return acc;
    endfunction

    function automatic out_item_t mm_result(input in_item_t it);
        out_item_t r;
        r.result = '0;
        r.status = STATUS_OK;
        case (it.func)
            FUNC_PREPARE: begin
                if (!modulus_q[0] || modulus_q[63:32] == 32'd0) begin
                    prepared_q = 1'b0;
                    r.status   = STATUS_BAD_MOD;
                end else begin
                    neg_inv_q  = newton_neg_inv(modulus_q[31:0]);
                    r_sq_q     = r_squared_mod(modulus_q, neg_inv_q);
                    prepared_q = 1'b1;
                    r.result   = r_sq_q;
                end
            end
            FUNC_PRODUCT, FUNC_CONVERT: begin
                if (!prepared_q) begin
                    r.status = STATUS_NOT_PREP;
                end else if (it.func == FUNC_PRODUCT) begin
                    r.result = mont_mul(it.operand_a, it.operand_b, modulus_q, neg_inv_q);
                end else begin
                    r.result = mont_mul(it.operand_a, r_sq_q, modulus_q, neg_inv_q);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            modulus_q  = MOD_RESET;
            neg_inv_q  = '0;
            r_sq_q     = '0;
            prepared_q = 1'b0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no item outstanding: result %h status %0d",
                           m_data.result, m_data.status);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    compared++;
                    if (m_data.result !== want.result) begin
                        $error("result: expected %h, got %h", want.result, m_data.result);
                        errors++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                modulus_q  = cfg_data;
                prepared_q = 1'b0;
            end
            if (s_valid && s_ready) begin
                due_results.push_back(mm_result(s_data));
            end
        end
        n_pending  <= due_results.size();
        n_errors   <= errors;
        n_compared <= compared;
    end

endmodule

[tb/tb_montgomery_mul_64bit.sv]
// Testbench top for the 64-bit Montgomery multiplier: drives modulus writes and
// items under varying idle patterns and gives the verdict.
// Depends on mm64_pkg, montgomery_mul_64bit and mm64_checker.
module tb_montgomery_mul_64bit;
    import mm64_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;

    int          pending;
    int          errors;
    int          compared;
    int          src_pct   = 0;
    int          sink_pct  = 0;
    int          sent[4]   = '{0, 0, 0, 0};
    int          n_settings = 0;
    logic [63:0] cur_mod   = MOD_RESET;

    always #4 aclk = ~aclk;

    montgomery_mul_64bit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    mm64_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .n_pending  (pending),
        .n_errors   (errors),
        .n_compared (compared)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_pct);
        end
    end

    task automatic send(input logic [1:0] f, input logic [63:0] a, input logic [63:0] b);
        in_item_t it;
        it.func      = f;
        it.operand_a = a;
        it.operand_b = b;
        if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent[f]++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [63:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_mod = v;
        n_settings++;
    endtask

    function automatic logic [63:0] pick_modulus();
        logic [63:0] v;
        int          kind;
        v    = {$urandom, $urandom};
        kind = $urandom_range(0, 11);
        case (kind)
            0: v[63:32] = $urandom_range(1, 255);
            1: v = '1;
            2: v = MOD_RESET;
            3: v[0] = 1'b0;
            4: v[63:32] = '0;
            5: v[63] = 1'b1;
            default: ;
        endcase
        if (kind != 3 && kind != 4) begin
            v[0] = 1'b1;
            if (v[63:32] == 32'd0) begin
                v[32] = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic logic [63:0] pick_operand();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return cur_mod - 64'd1;
            2: return '1;
            3: return raw;
            default: return (cur_mod != 0) ? raw % cur_mod : raw;
        endcase
    endfunction

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int         r;
        logic [1:0] f;
        idle_mode_t mode;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset modulus, used first without and then with a prepare.
        send(FUNC_PRODUCT, 64'd1, 64'd2);
        send(FUNC_CONVERT, 64'd5, 64'd0);
        send(FUNC_UNUSED, '1, '1);
        send(FUNC_PREPARE, '0, '0);
        send(FUNC_PRODUCT, '0, '0);
        send(FUNC_PRODUCT, cur_mod - 64'd1, cur_mod - 64'd1);
        send(FUNC_PRODUCT, '1, '1);
        send(FUNC_CONVERT, cur_mod - 64'd1, '0);
        send(FUNC_CONVERT, '1, '1);
        send(FUNC_UNUSED, '1, '1);
        wait_idle();

        // Unusable moduli: even, high word zero, and zero.
        write_modulus(64'hFFFF_FFFF_FFFF_FFFE);
        send(FUNC_PRODUCT, 64'd3, 64'd4);
        send(FUNC_PREPARE, '0, '0);
        send(FUNC_CONVERT, 64'd7, '0);
        write_modulus(64'h0000_0000_FFFF_FFFF);
        send(FUNC_PREPARE, '1, '1);
        write_modulus(64'd0);
        send(FUNC_PREPARE, '0, '0);

        write_modulus('1);
        send(FUNC_PREPARE, '0, '0);
        send(FUNC_PRODUCT, cur_mod - 64'd1, cur_mod - 64'd1);
        send(FUNC_CONVERT, 64'd1, '0);
        send(FUNC_PRODUCT, '1, '0);

        write_modulus(64'h8000_0000_0000_0001);
        send(FUNC_PREPARE, '0, '0);
        send(FUNC_PRODUCT, pick_operand(), pick_operand());
        send(FUNC_PREPARE, '1, '1);
        send(FUNC_CONVERT, pick_operand(), '0);

        for (int seg = 0; seg < 12; seg++) begin
            mode = idle_mode_t'(seg % 4);
            write_modulus(pick_modulus());
            case (mode)
                IDLE_SRC:  begin src_pct = 69; sink_pct = 0;  end
                IDLE_SINK: begin src_pct = 0;  sink_pct = 69; end
                IDLE_BOTH: begin src_pct = 15; sink_pct = 15; end
                default:   begin src_pct = 0;  sink_pct = 0;  end
            endcase
            if ($urandom_range(0, 9) != 0) begin
                send(FUNC_PREPARE, pick_operand(), pick_operand());
            end
            for (int k = 0; k < 100; k++) begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    wait_idle();
                end
                if (r < 6) begin
                    f = FUNC_PREPARE;
                end else if (r < 10) begin
                    f = FUNC_UNUSED;
                end else if (r < 70) begin
                    f = FUNC_PRODUCT;
                end else begin
                    f = FUNC_CONVERT;
                end
                send(f, pick_operand(), pick_operand());
            end
        end

        s_valid <= 1'b0;
        sink_pct = 0;
        @(posedge aclk);
        for (int k = 0; k < 20000 && pending != 0; k++) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d prepares, %0d products, %0d conversions and %0d unused codes",
                 sent[FUNC_PREPARE], sent[FUNC_PRODUCT], sent[FUNC_CONVERT], sent[FUNC_UNUSED]);
        $display("over %0d modulus settings; %0d results compared, %0d mismatches, %0d missing.",
                 n_settings + 1, compared, errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
